[rtl/core/lpe_pkg.sv]
// Shared types, constants and constant functions of the Legendre evaluator.
// Depends on nothing; every module of the block imports it.
package lpe_pkg;

   localparam int MAX_DEGREE_DEF = 32;

   // Working values: signed Q.30, saturated to +-(2^62 - 1)
   localparam int VAL_W = 63;
   typedef logic signed [VAL_W-1:0] val_type;

   localparam val_type ONE_Q30 = val_type'(64'h4000_0000);
   localparam val_type INT_LIM = val_type'(64'h3FFF_FFFF_FFFF_FFFF);
   localparam val_type OUT_MAX = val_type'(64'h7FFF_FFFF_FFFF);
   localparam val_type OUT_MIN = -val_type'(64'h8000_0000_0000);

   // sqrt(2n+1) table width (Q.30, n up to 255)
   localparam int SQ_W = 36;

   // Status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_SAT  = 2'd1;
   localparam logic [1:0] ST_DIV0 = 2'd2;

   // Function selector bits
   localparam int FUNC_DERIV_BIT = 0;
   localparam int FUNC_SCALE_BIT = 1;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_MUL,
      OP_DIV,
      OP_T_MUL,
      OP_A_MUL,
      OP_STEP,
      OP_DEN,
      OP_NUM,
      OP_RES_P,
      OP_RES_ZERO,
      OP_RES_MUL,
      OP_RES_DIV,
      OP_DIV0,
      OP_EMIT
   } op_type;

   // Multiplier operand pairs
   typedef enum logic [2:0] {
      MS_XP,   // x * p
      MS_TC2,  // t * (2 - 1/k)
      MS_PC1,  // pm1 * (1 - 1/k)
      MS_XX,   // x * x
      MS_TN,   // t * n
      MS_RS    // res * sqrt(2n+1)
   } msel_type;

   typedef struct packed {
      op_type   op;
      msel_type msel;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic loop_go;
      logic n_zero;
      logic mul_one;
      logic deriv;
      logic scale;
      logic out_free;
   } stat_type;

   function automatic logic [VAL_W-1:0] mag63(input val_type v);
      return v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
   endfunction

   // floor(sqrt((2n+1) * 2^60)); elaboration-time only
   function automatic logic [SQ_W-1:0] sqrt_q30(input int unsigned n);
      logic [83:0] tgt;
      logic [83:0] sq;
      logic [41:0] s;
      logic [41:0] c;
      s   = '0;
      tgt = 84'(2 * n + 1) << 60;
      for (int b = 41; b >= 0; b--) begin
         c  = s | (42'(1) << b);
         sq = 84'(c) * 84'(c);
         if (sq <= tgt) s = c;
      end
      return SQ_W'(s);
   endfunction

endpackage

[rtl/core/lpe_ifs.sv]
// Request and response channel interfaces of the Legendre evaluator.
// Valid/ready handshake; no dependencies.
interface lpe_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] x;
   logic        [5:0]  degree;
   logic        [1:0]  func;

   modport source (output valid, x, degree, func, input ready);
   modport sink   (input valid, x, degree, func, output ready);
endinterface

interface lpe_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [47:0] value;
   logic        [1:0]  status;

   modport source (output valid, value, status, input ready);
   modport sink   (input valid, value, status, output ready);
endinterface

[rtl/core/legendre_polynomial_eval_top.sv]
// Legendre polynomial evaluator. Each request brings x (signed Q1.30), a degree n
// (clamped to MAX_DEGREE) and a selector: P_n(x), its derivative
// n(x*P_n - P_{n-1})/(x^2 - 1), or either scaled by sqrt(2n+1). The response is a
// signed Q17.30 value with status ok, saturated, or division by zero (x = +-1,
// value 0). Derivative of degree zero is 0. All products round half away from
// zero in Q.30; intermediates saturate at +-(2^62 - 1). One request is in flight
// at a time; the next is accepted once the previous result sits in the output
// register. One shared multiplier builds each product from four 32x32 partial
// products. P_n takes three multiplies per recurrence step; a derivative adds
// three more multiplies and a 92-step restoring divide, and scaling adds one
// more multiply. Coefficient tables (1/k, sqrt(2n+1)) are constants built at
// elaboration.
// Depends on lpe_pkg, lpe_ifs, lpe_ctrl, lpe_datapath.
module legendre_polynomial_eval_top import lpe_pkg::*; #(
   parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
   input logic        clock,
   input logic        reset,
   lpe_req_if.sink    req_ch,
   lpe_rsp_if.source  rsp_ch
);
   cmd_type  cmd;
   stat_type st;
   logic     req_ready;

   assign req_ch.ready = req_ready;

   // Sequencer: one command per cycle to the datapath, waiting on the multiplier, divider and output register
   lpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .st        (st),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   // Datapath captures the request on the accepting edge
   lpe_datapath #(
      .MAX_DEGREE (MAX_DEGREE)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .st         (st),
      .load       (req_ch.valid && req_ready),
      .req_x      (req_ch.x),
      .req_degree (req_ch.degree),
      .req_func   (req_ch.func),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .rsp_value  (rsp_ch.value),
      .rsp_status (rsp_ch.status)
   );
endmodule

[rtl/core/lpe_mul.sv]
// Sequential Q.30 multiplier: four 32x32 partial products, round, saturate.
// Depends on lpe_pkg.
module lpe_mul import lpe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  val_type opa,
   input  val_type opb,
   output val_type product,
   output logic    sat,
   output logic    done,
   output logic    busy
);
   localparam logic [2:0] PP_CNT = 3'd4;
   localparam logic [2:0] LAST   = 3'd5;

   logic [VAL_W-1:0] ma_ff, mb_ff;
   logic             neg_ff;
   logic [2:0]       cnt_ff;
   logic             busy_ff, done_ff;
   logic [63:0]      pp_ff;
   logic [1:0]       sh_ff;
   logic [127:0]     acc_ff;
   val_type          prod_ff;
   logic             sat_ff;

   logic [31:0]      a_ch, b_ch;
   logic [63:0]      pp;
   logic [1:0]       sh;
   logic [127:0]     pp_sh, sum;
   logic [97:0]      m;
   logic             over;
   logic [VAL_W-1:0] mag;

   always_comb begin
      a_ch  = cnt_ff[1] ? {1'b0, ma_ff[62:32]} : ma_ff[31:0];
      b_ch  = cnt_ff[0] ? {1'b0, mb_ff[62:32]} : mb_ff[31:0];
      pp    = a_ch * b_ch;
      sh    = {1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]};
      case (sh_ff)
         2'd0:    pp_sh = {64'b0, pp_ff};
         2'd1:    pp_sh = {32'b0, pp_ff, 32'b0};
         default: pp_sh = {pp_ff, 64'b0};
      endcase
      sum  = acc_ff + 128'h2000_0000;
      m    = sum[127:30];
      over = m > 98'(INT_LIM);
      mag  = over ? VAL_W'(INT_LIM) : m[VAL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff == LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ma_ff  <= mag63(opa);
         mb_ff  <= mag63(opb);
         neg_ff <= opa[VAL_W-1] != opb[VAL_W-1];
         acc_ff <= '0;
      end else if (busy_ff) begin
         if (cnt_ff < PP_CNT) begin
            pp_ff <= pp;
            sh_ff <= sh;
         end
         if (cnt_ff != 3'd0 && cnt_ff <= PP_CNT) acc_ff <= acc_ff + pp_sh;
         if (cnt_ff == LAST) begin
            prod_ff <= neg_ff ? -val_type'(mag) : val_type'(mag);
            sat_ff  <= over;
         end
      end
   end

   assign product = prod_ff;
   assign sat     = sat_ff;
   assign done    = done_ff;
   assign busy    = busy_ff;
endmodule

[rtl/core/lpe_div.sv]
// Restoring divider for the derivative quotient: |num|*2^30 / |den|,
// one quotient bit per cycle, truncated toward zero, saturated. Depends on lpe_pkg.
module lpe_div import lpe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  val_type num,
   input  val_type den,
   output val_type quotient,
   output logic    sat,
   output logic    done,
   output logic    busy
);
   localparam int         DVD_W = VAL_W - 1 + 30;
   localparam logic [6:0] STEPS = 7'(DVD_W);

   logic [VAL_W-1:0] ud_ff, rem_ff;
   logic [DVD_W-1:0] dvd_ff, q_ff;
   logic             neg_ff;
   logic [6:0]       cnt_ff;
   logic             busy_ff, done_ff;
   val_type          quo_ff;
   logic             sat_ff;

   logic [VAL_W-1:0] un;
   logic [VAL_W:0]   r2, diff;
   logic             ge, over;
   logic [VAL_W-1:0] mag;

   always_comb begin
      un   = mag63(num);
      r2   = {rem_ff, dvd_ff[DVD_W-1]};
      diff = r2 - {1'b0, ud_ff};
      ge   = r2 >= {1'b0, ud_ff};
      over = q_ff > DVD_W'(INT_LIM);
      mag  = over ? VAL_W'(INT_LIM) : q_ff[VAL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 7'd1;
            if (cnt_ff == STEPS) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ud_ff  <= mag63(den);
         dvd_ff <= {un[VAL_W-2:0], 30'b0};
         rem_ff <= '0;
         neg_ff <= num[VAL_W-1] != den[VAL_W-1];
      end else if (busy_ff) begin
         if (cnt_ff < STEPS) begin
            rem_ff <= ge ? diff[VAL_W-1:0] : r2[VAL_W-1:0];
            q_ff   <= {q_ff[DVD_W-2:0], ge};
            dvd_ff <= {dvd_ff[DVD_W-2:0], 1'b0};
         end else begin
            quo_ff <= neg_ff ? -val_type'(mag) : val_type'(mag);
            sat_ff <= over;
         end
      end
   end

   assign quotient = quo_ff;
   assign sat      = sat_ff;
   assign done     = done_ff;
   assign busy     = busy_ff;
endmodule

[rtl/core/lpe_datapath.sv]
// Datapath: item registers, coefficient tables, shared multiplier and divider,
// output register. Executes commands from lpe_ctrl. Depends on lpe_pkg, lpe_mul, lpe_div.
module lpe_datapath import lpe_pkg::*; #(
   parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           st,
   input  logic               load,
   input  logic signed [31:0] req_x,
   input  logic        [5:0]  req_degree,
   input  logic        [1:0]  req_func,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [47:0] rsp_value,
   output logic        [1:0]  rsp_status
);
   localparam int DW = (MAX_DEGREE < 2) ? 1 : $clog2(MAX_DEGREE + 1);
   localparam int KW = $clog2(MAX_DEGREE + 2);

   // Recurrence coefficients 2 - 1/k, 1 - 1/k and sqrt(2n+1), all Q.30
   logic [31:0]     c2_tab [MAX_DEGREE+1];
   logic [31:0]     c1_tab [MAX_DEGREE+1];
   logic [SQ_W-1:0] sq_tab [MAX_DEGREE+1];

   for (genvar g = 0; g <= MAX_DEGREE; g++) begin : g_tab
      localparam int KD = (g < 2) ? 2 : g;
      localparam int RC = ((1 << 30) + KD / 2) / KD;
      localparam logic [SQ_W-1:0] SQ = sqrt_q30(g);
      assign c2_tab[g] = 32'h8000_0000 - 32'(RC);
      assign c1_tab[g] = 32'h4000_0000 - 32'(RC);
      assign sq_tab[g] = SQ;
   end

   logic signed [31:0] x_ff;
   logic [DW-1:0]      n_ff;
   logic [1:0]         func_ff;
   logic [KW-1:0]      k_ff;
   val_type            p_ff, pm1_ff, t_ff, a_ff, res_ff;
   logic               sat_ff, st2_ff;
   logic               rsp_valid_ff;
   logic signed [47:0] value_ff;
   logic [1:0]         status_ff;

   val_type   xv, opa, opb, mres, dres, step_v, num_v;
   logic      mul_start, div_start, mul_sat, mul_done, mul_busy;
   logic      div_sat, div_done, div_busy, step_s, num_s;
   logic      out_hi, out_lo, out_free;
   logic [31:0] deg_c;

   function automatic logic [VAL_W:0] sat_add(input val_type a, input val_type b);
      logic signed [VAL_W:0] s;
      s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
      if (s > (VAL_W+1)'(INT_LIM)) return {1'b1, INT_LIM};
      if (s < -(VAL_W+1)'(INT_LIM)) return {1'b1, -INT_LIM};
      return {1'b0, s[VAL_W-1:0]};
   endfunction

   always_comb begin
      xv    = val_type'(x_ff);
      deg_c = (32'(req_degree) > 32'(MAX_DEGREE)) ? 32'(MAX_DEGREE) : 32'(req_degree);
      case (cmd.msel)
         MS_XP: begin
            opa = xv;
            opb = p_ff;
         end
         MS_TC2: begin
            opa = t_ff;
            opb = val_type'(c2_tab[k_ff[DW-1:0]]);
         end
         MS_PC1: begin
            opa = pm1_ff;
            opb = val_type'(c1_tab[k_ff[DW-1:0]]);
         end
         MS_XX: begin
            opa = xv;
            opb = xv;
         end
         MS_TN: begin
            opa = t_ff;
            opb = val_type'({n_ff, 30'b0});
         end
         default: begin
            opa = res_ff;
            opb = val_type'(sq_tab[n_ff]);
         end
      endcase
      {step_s, step_v} = sat_add(a_ff, -mres);
      {num_s, num_v}   = sat_add(mres, -pm1_ff);
      out_hi   = res_ff > OUT_MAX;
      out_lo   = res_ff < OUT_MIN;
      out_free = !rsp_valid_ff || rsp_ready;
   end

   assign mul_start = cmd.op == OP_MUL;
   assign div_start = cmd.op == OP_DIV;

   lpe_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .opa     (opa),
      .opb     (opb),
      .product (mres),
      .sat     (mul_sat),
      .done    (mul_done),
      .busy    (mul_busy)
   );

   lpe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (t_ff),
      .den      (a_ff),
      .quotient (dres),
      .sat      (div_sat),
      .done     (div_done),
      .busy     (div_busy)
   );

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff    <= req_x;
         n_ff    <= deg_c[DW-1:0];
         func_ff <= req_func;
         k_ff    <= KW'(2);
         p_ff    <= (deg_c == 32'd0) ? ONE_Q30 : val_type'(req_x);
         pm1_ff  <= ONE_Q30;
         sat_ff  <= 1'b0;
         st2_ff  <= 1'b0;
      end else begin
         if ((mul_done && mul_sat) || (div_done && div_sat)) sat_ff <= 1'b1;
         case (cmd.op)
            OP_T_MUL:    t_ff <= mres;
            OP_A_MUL:    a_ff <= mres;
            OP_STEP: begin
               pm1_ff <= p_ff;
               p_ff   <= step_v;
               k_ff   <= k_ff + KW'(1);
               if (step_s) sat_ff <= 1'b1;
            end
            OP_DEN:      a_ff <= mres - ONE_Q30;
            OP_NUM: begin
               t_ff <= num_v;
               if (num_s) sat_ff <= 1'b1;
            end
            OP_RES_P:    res_ff <= p_ff;
            OP_RES_ZERO: res_ff <= '0;
            OP_RES_MUL:  res_ff <= mres;
            OP_RES_DIV:  res_ff <= dres;
            OP_DIV0: begin
               res_ff <= '0;
               st2_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_EMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_EMIT) begin
         if (st2_ff) begin
            value_ff  <= '0;
            status_ff <= ST_DIV0;
         end else begin
            value_ff  <= out_hi ? OUT_MAX[47:0] : out_lo ? OUT_MIN[47:0] : res_ff[47:0];
            status_ff <= (sat_ff || out_hi || out_lo) ? ST_SAT : ST_OK;
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = value_ff;
   assign rsp_status = status_ff;

   assign st.mul_done = mul_done;
   assign st.div_done = div_done;
   assign st.loop_go  = k_ff <= KW'(n_ff);
   assign st.n_zero   = n_ff == '0;
   assign st.mul_one  = mres == ONE_Q30;
   assign st.deriv    = func_ff[FUNC_DERIV_BIT];
   assign st.scale    = func_ff[FUNC_SCALE_BIT];
   assign st.out_free = out_free;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_EMIT |-> out_free)
      else $error("emit while output register full");

   a_div0_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == ST_DIV0 |-> value_ff == '0)
      else $error("division-by-zero response carries nonzero value");

   a_mul_idle: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_busy && !div_busy)
      else $error("multiply started while a unit is busy");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy && !mul_busy)
      else $error("divide started while a unit is busy");
endmodule

[rtl/core/lpe_ctrl.sv]
// Sequencer: walks the recurrence, the derivative and the scaling by issuing
// datapath commands one at a time. Depends on lpe_pkg.
module lpe_ctrl import lpe_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  stat_type st,
   input  logic     req_valid,
   output logic     req_ready,
   output cmd_type  cmd
);
   typedef enum logic [4:0] {
      S_IDLE, S_LOOP, S_W1, S_M2, S_W2, S_M3, S_W3, S_STEP,
      S_POST, S_WD, S_N, S_WN, S_NN, S_WNN, S_DV, S_WDV,
      S_SCALE, S_WS, S_OUT
   } state_type;

   state_type state_ff;
   cmd_type   cmd_ff;
   logic      ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         ready_ff    <= 1'b0;
         cmd_ff.op   <= OP_NONE;
         cmd_ff.msel <= MS_XP;
      end else begin
         cmd_ff.op   <= OP_NONE;
         cmd_ff.msel <= MS_XP;
         case (state_ff)
            S_IDLE: begin
               ready_ff <= !(req_valid && ready_ff);
               if (req_valid && ready_ff) state_ff <= S_LOOP;
            end
            S_LOOP: begin
               if (st.loop_go) begin
                  cmd_ff.op <= OP_MUL;
                  state_ff  <= S_W1;
               end else begin
                  state_ff <= S_POST;
               end
            end
            S_W1: if (st.mul_done) begin
               cmd_ff.op <= OP_T_MUL;
               state_ff  <= S_M2;
            end
            S_M2: begin
               cmd_ff.op   <= OP_MUL;
               cmd_ff.msel <= MS_TC2;
               state_ff    <= S_W2;
            end
            S_W2: if (st.mul_done) begin
               cmd_ff.op <= OP_A_MUL;
               state_ff  <= S_M3;
            end
            S_M3: begin
               cmd_ff.op   <= OP_MUL;
               cmd_ff.msel <= MS_PC1;
               state_ff    <= S_W3;
            end
            S_W3: if (st.mul_done) begin
               cmd_ff.op <= OP_STEP;
               state_ff  <= S_STEP;
            end
            S_STEP: state_ff <= S_LOOP;
            S_POST: begin
               if (!st.deriv) begin
                  cmd_ff.op <= OP_RES_P;
                  state_ff  <= S_SCALE;
               end else if (st.n_zero) begin
                  cmd_ff.op <= OP_RES_ZERO;
                  state_ff  <= S_SCALE;
               end else begin
                  cmd_ff.op   <= OP_MUL;
                  cmd_ff.msel <= MS_XX;
                  state_ff    <= S_WD;
               end
            end
            S_WD: if (st.mul_done) begin
               if (st.mul_one) begin
                  cmd_ff.op <= OP_DIV0;
                  state_ff  <= S_OUT;
               end else begin
                  cmd_ff.op <= OP_DEN;
                  state_ff  <= S_N;
               end
            end
            S_N: begin
               cmd_ff.op <= OP_MUL;
               state_ff  <= S_WN;
            end
            S_WN: if (st.mul_done) begin
               cmd_ff.op <= OP_NUM;
               state_ff  <= S_NN;
            end
            S_NN: begin
               cmd_ff.op   <= OP_MUL;
               cmd_ff.msel <= MS_TN;
               state_ff    <= S_WNN;
            end
            S_WNN: if (st.mul_done) begin
               cmd_ff.op <= OP_T_MUL;
               state_ff  <= S_DV;
            end
            S_DV: begin
               cmd_ff.op <= OP_DIV;
               state_ff  <= S_WDV;
            end
            S_WDV: if (st.div_done) begin
               cmd_ff.op <= OP_RES_DIV;
               state_ff  <= S_SCALE;
            end
            S_SCALE: begin
               if (st.scale) begin
                  cmd_ff.op   <= OP_MUL;
                  cmd_ff.msel <= MS_RS;
                  state_ff    <= S_WS;
               end else begin
                  state_ff <= S_OUT;
               end
            end
            S_WS: if (st.mul_done) begin
               cmd_ff.op <= OP_RES_MUL;
               state_ff  <= S_OUT;
            end
            S_OUT: if (st.out_free) begin
               cmd_ff.op <= OP_EMIT;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = ready_ff;
   assign cmd       = cmd_ff;
endmodule
